// File: hw/rtl/tksi_pkg.sv
// Shared types, sizes and helpers for the top-k selection unit.
// No dependencies; every other file refers to this package by scoped names.
package tksi_pkg;

   localparam int MAX_TOP         = 8;
   localparam int MAX_CLASSES     = 1024;
   localparam int SCORE_W         = 16;
   localparam int INDEX_W         = $clog2(MAX_CLASSES);
   localparam int CLASS_INDEX_W   = 10;
   localparam int CNT_W           = $clog2(MAX_TOP + 1);
   localparam int CFG_W           = 4;
   localparam int TOP_COUNT_RESET = 5;

   typedef logic [SCORE_W-1:0]       score_type;
   typedef logic [INDEX_W-1:0]       index_type;
   typedef logic [CLASS_INDEX_W-1:0] class_index_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [CFG_W-1:0]         cfg_type;

   typedef struct packed {
      score_type score;
      index_type index;
   } entry_type;

   // Map the raw register value onto a report length of 1..MAX_TOP.
   function automatic cnt_type clamp_top(cfg_type cfg);
      int c;
      c = int'(cfg);
      if (c < 1) begin
         c = 1;
      end else if (c > MAX_TOP) begin
         c = MAX_TOP;
      end
      return cnt_type'(c);
   endfunction

endpackage

// File: hw/rtl/tksi_stream_if.sv
// Valid/ready channels for the top-k selection unit: score requests and
// ranked responses. Depends on tksi_pkg for the payload types.
interface tksi_req_if;
   logic               valid;
   logic               ready;
   tksi_pkg::score_type score;
   logic               final_score;

   modport source (output valid, output score, output final_score, input ready);
   modport sink   (input valid, input score, input final_score, output ready);
endinterface

interface tksi_rsp_if;
   logic                     valid;
   logic                     ready;
   tksi_pkg::score_type      best_score;
   tksi_pkg::class_index_type class_index;
   logic                     run_end;

   modport source (output valid, output best_score, output class_index, output run_end,
                   input ready);
   modport sink   (input valid, input best_score, input class_index, input run_end,
                   output ready);
endinterface

// File: hw/rtl/tksi_insert.sv
// One-step sorted insert of a scored entry into the kept list.
// Depends on tksi_pkg; purely combinational.
module tksi_insert (
   input  tksi_pkg::entry_type kept_i [tksi_pkg::MAX_TOP],
   input  tksi_pkg::cnt_type   count_i,
   input  tksi_pkg::entry_type entry_i,
   output tksi_pkg::entry_type kept_o [tksi_pkg::MAX_TOP],
   output tksi_pkg::cnt_type   count_o
);

   // ge[i]: kept entry i is valid and ranks at or above the new one
   // (equal scores keep the earlier index first)
   logic [tksi_pkg::MAX_TOP-1:0] ge;

   always_comb begin
      for (int i = 0; i < tksi_pkg::MAX_TOP; i++) begin
         ge[i] = (tksi_pkg::cnt_type'(i) < count_i) && (kept_i[i].score >= entry_i.score);
      end
   end

   // keep above the slot, place at the slot, shift down below it
   always_comb begin
      kept_o[0] = ge[0] ? kept_i[0] : entry_i;
      for (int i = 1; i < tksi_pkg::MAX_TOP; i++) begin
         if (ge[i]) begin
            kept_o[i] = kept_i[i];
         end else if (ge[i-1]) begin
            kept_o[i] = entry_i;
         end else begin
            kept_o[i] = kept_i[i-1];
         end
      end
   end

   assign count_o = (count_i < tksi_pkg::cnt_type'(tksi_pkg::MAX_TOP))
                    ? count_i + tksi_pkg::cnt_type'(1) : count_i;

endmodule

// File: hw/rtl/top_k_select_with_index_unit.sv
// Top level of the streaming top-k selection unit.
// Depends on tksi_pkg, tksi_stream_if and tksi_insert.
//
// Scores stream in one per cycle on req_ch while req_ch.ready is high; each is
// numbered by its position in the vector (from 0, saturating at MAX_CLASSES-1)
// and placed into a sorted list of the MAX_TOP best in the same cycle by parallel
// compares against every kept entry (ties keep the earlier index first). The score
// flagged final_score closes the vector: the list, including that score, moves
// into a response buffer and the list clears, so the next vector can start on the
// very next cycle. The buffer then delivers min(top_count, scores seen) results on
// rsp_ch, one per cycle while rsp_ch.ready is high, best first, with run_end on the
// last. Non-final scores are taken every cycle regardless of the response side; a
// final score waits only while the buffer still holds results of the previous
// vector beyond the one leaving this cycle. top_count (csr_wdata, written with
// csr_we) is read as 1..MAX_TOP: zero means one, larger values mean MAX_TOP. It
// resets to 5; write it only while idle.
module top_k_select_with_index_unit (
   input  logic                  clock,
   input  logic                  reset,
   tksi_req_if.sink              req_ch,
   tksi_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  tksi_pkg::cfg_type     csr_wdata
);

   // configuration
   tksi_pkg::cfg_type top_count_ff;

   // kept list and stream position
   tksi_pkg::entry_type kept_ff  [tksi_pkg::MAX_TOP];
   tksi_pkg::entry_type kept_in  [tksi_pkg::MAX_TOP];
   tksi_pkg::cnt_type   count_ff;
   tksi_pkg::cnt_type   count_in;
   tksi_pkg::index_type position_ff;
   tksi_pkg::entry_type entry;

   // response buffer: entry 0 is the one on the port
   tksi_pkg::entry_type out_ff   [tksi_pkg::MAX_TOP];
   tksi_pkg::cnt_type   left_ff;
   tksi_pkg::cnt_type   report_n;

   logic req_xfer;
   logic rsp_xfer;
   logic out_free;
   logic close_vec;

   assign entry.score = req_ch.score;
   assign entry.index = position_ff;

   tksi_insert u_insert (
      .kept_i  (kept_ff),
      .count_i (count_ff),
      .entry_i (entry),
      .kept_o  (kept_in),
      .count_o (count_in)
   );

   // buffer can take a new vector when empty or when its last result leaves now
   assign rsp_xfer  = rsp_ch.valid && rsp_ch.ready;
   assign out_free  = (left_ff == '0)
                      || ((left_ff == tksi_pkg::cnt_type'(1)) && rsp_ch.ready);
   assign req_ch.ready = !req_ch.final_score || out_free;
   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign close_vec = req_xfer && req_ch.final_score;

   // report length: clamped register value, limited by what was kept
   always_comb begin
      report_n = tksi_pkg::clamp_top(top_count_ff);
      if (count_in < report_n) begin
         report_n = count_in;
      end
   end

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= tksi_pkg::cfg_type'(tksi_pkg::TOP_COUNT_RESET);
      end else if (csr_we) begin
         top_count_ff <= csr_wdata;
      end
   end

   // kept list: insert on every non-final transfer, clear after the final score
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         position_ff <= '0;
      end else if (req_xfer) begin
         if (req_ch.final_score) begin
            count_ff    <= '0;
            position_ff <= '0;
         end else begin
            count_ff <= count_in;
            if (position_ff != tksi_pkg::index_type'(tksi_pkg::MAX_CLASSES - 1)) begin
               position_ff <= position_ff + tksi_pkg::index_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !req_ch.final_score) begin
         kept_ff <= kept_in;
      end
   end

   // response buffer: load on vector close, advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (close_vec) begin
         left_ff <= report_n;
      end else if (rsp_xfer) begin
         left_ff <= left_ff - tksi_pkg::cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (close_vec) begin
         out_ff <= kept_in;
      end else if (rsp_xfer) begin
         for (int i = 0; i < tksi_pkg::MAX_TOP - 1; i++) begin
            out_ff[i] <= out_ff[i+1];
         end
      end
   end

   assign rsp_ch.valid       = (left_ff != '0);
   assign rsp_ch.best_score  = out_ff[0].score;
   assign rsp_ch.class_index = tksi_pkg::class_index_type'(out_ff[0].index);
   assign rsp_ch.run_end     = (left_ff == tksi_pkg::cnt_type'(1));

endmodule

// File: hw/rtl/tksi_checker.sv
// Port-level checks for the top-k selection unit, bound to the top level.
// Depends on tksi_pkg and top_k_select_with_index_unit.
module tksi_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_final_score,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input tksi_pkg::score_type       rsp_best_score,
   input tksi_pkg::class_index_type rsp_class_index,
   input logic                      rsp_run_end
);

   // no results straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_best_score)
                                    && $stable(rsp_class_index) && $stable(rsp_run_end)))
      else $error("stalled response changed");

   // a vector closes only when the previous report is done or finishing
   a_close_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_final_score)
         |-> (!rsp_valid || (rsp_ready && rsp_run_end)))
      else $error("vector closed over a pending report");

   // closing a vector always yields at least one result
   a_close_reports: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_final_score) |=> rsp_valid)
      else $error("closed vector produced no result");

   // a report runs without gaps up to run_end
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_end) |=> rsp_valid)
      else $error("report ended without run_end");

endmodule

bind top_k_select_with_index_unit tksi_checker u_tksi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_final_score (req_ch.final_score),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_best_score  (rsp_ch.best_score),
   .rsp_class_index (rsp_ch.class_index),
   .rsp_run_end     (rsp_ch.run_end)
);
